// ===== src/fixed_array_table_engine_macros.svh =====
// assertion helpers shared by the table engine modules
// both forms expect clk and arst_n in scope
`ifndef FIXED_ARRAY_TABLE_ENGINE_MACROS_SVH
`define FIXED_ARRAY_TABLE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define FATE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define FATE_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant check failed");
`else
`define FATE_ASSERT_IMP(lbl, ante, cons)
`define FATE_ASSERT_ALWAYS(lbl, expr)
`endif
`endif

// ===== src/fate_pkg.sv =====
package fate_pkg;

	// field widths of the stream items and the register
	localparam int POS_W      = 5;
	localparam int WORD_W     = 32;
	localparam int AMT_W      = 16;
	localparam int ACT_W      = 3;
	localparam int FPOS_W     = 4;
	localparam int CNT_OUT_W  = 5;
	localparam int CAP_W      = 5;
	localparam int ST_W       = 2;
	localparam int S_USED_W   = POS_W + WORD_W + AMT_W;
	localparam int S_TDATA_W  = 56;
	localparam int M_USED_W   = WORD_W + 1 + FPOS_W + CNT_OUT_W;
	localparam int M_TDATA_W  = 48;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request kinds
	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 3'd0,
		ACT_GET    = 3'd1,
		ACT_DELETE = 3'd2,
		ACT_FIND   = 3'd3,
		ACT_ROTATE = 3'd4
	} action_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// index register operations
	typedef enum logic [2:0] {
		IX_KEEP    = 3'd0,
		IX_CNT     = 3'd1,
		IX_POS     = 3'd2,
		IX_ZERO    = 3'd3,
		IX_DN      = 3'd4,
		IX_UP      = 3'd5,
		IX_RV_SET  = 3'd6,
		IX_RV_STEP = 3'd7
	} idx_op_t;

	typedef enum logic [2:0] {
		RA_A   = 3'd0,
		RA_B   = 3'd1,
		RA_DN  = 3'd2,
		RA_UP  = 3'd3,
		RA_POS = 3'd4
	} raddr_sel_t;

	typedef enum logic [1:0] {
		WA_A   = 2'd0,
		WA_B   = 2'd1,
		WA_POS = 2'd2
	} waddr_sel_t;

	typedef enum logic [1:0] {
		WD_RDATA = 2'd0,
		WD_HOLD  = 2'd1,
		WD_WORD  = 2'd2
	} wdata_sel_t;

	// controller to datapath
	typedef struct packed {
		logic       ld_req;
		idx_op_t    ix_op;
		logic       ph_inc;
		logic       rd_en;
		raddr_sel_t rd_sel;
		logic       wr_en;
		waddr_sel_t wr_sel;
		wdata_sel_t wd_sel;
		logic       hold_ld;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       st_set;
		status_t    st_code;
		logic       rd_cap;
		logic       fnd_set;
		logic       mod_start;
		logic       res_ld;
	} fate_cmd_t;

	// datapath to controller
	typedef struct packed {
		action_t act;
		logic    pos_gt_cnt;
		logic    pos_ge_cnt;
		logic    full;
		logic    cnt_zero;
		logic    ins_more;
		logic    ins_more_dn;
		logic    up_lt_cnt;
		logic    up2_lt_cnt;
		logic    a_lt_cnt;
		logic    lo_lt_hi;
		logic    match;
		logic    mod_done;
		logic    k_zero;
		logic    ph_last;
		logic    out_busy;
	} fate_sts_t;

endpackage

// ===== src/fixed_array_table_engine.sv =====
// m_tvalid rises once the request is handled: insert shifts entries up one by one, delete shifts them
// down, find compares entries in turn; rotate swaps nothing when the amount reduces to zero, else swaps
// entries over three reversals (up to count swaps in total)
// throughput: one request in flight; the next is taken the cycle after the result is loaded
// reset (arst_n low): count cleared, capacity_limit set to 16, no result pending; the stored
// words are not cleared and are only read below the count
module fixed_array_table_engine
	import fate_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // position, value, rotate_amount, zero pad
	input  logic [ACT_W-1:0]     s_tuser,   // action
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // read_value, found, found_position, count_now, pad
	output logic [ST_W-1:0]      m_tuser,   // status
	input  logic                 cfg_wen,
	input  logic [CAP_W-1:0]     cfg_wdata
);

	fate_cmd_t            cmd;
	fate_sts_t            sts;
	logic [POS_W-1:0]     req_position;
	logic [WORD_W-1:0]    req_value;
	logic [AMT_W-1:0]     req_amount;
	logic [WORD_W-1:0]    res_read_value;
	logic                 res_found;
	logic [FPOS_W-1:0]    res_fpos;
	logic [CNT_OUT_W-1:0] res_count;

	// unpack the input transfer
	assign req_position = s_tdata[POS_W-1:0];
	assign req_value    = s_tdata[POS_W+WORD_W-1:POS_W];
	assign req_amount   = s_tdata[S_USED_W-1:POS_W+WORD_W];

	fate_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fate_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.req_action    (s_tuser),
		.req_position  (req_position),
		.req_value     (req_value),
		.req_amount    (req_amount),
		.cmd           (cmd),
		.sts           (sts),
		.res_valid     (m_tvalid),
		.res_ready     (m_tready),
		.res_status    (m_tuser),
		.res_read_value(res_read_value),
		.res_found     (res_found),
		.res_fpos      (res_fpos),
		.res_count     (res_count)
	);

	// pack the result transfer
	assign m_tdata = {{(M_TDATA_W-M_USED_W){1'b0}}, res_count, res_fpos, res_found,
		res_read_value};

endmodule

// ===== src/fate_ram.sv =====
module fate_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/fate_mod.sv =====
`include "fixed_array_table_engine_macros.svh"
module fate_mod #(
	parameter int DIV_W = 5,
	parameter int NUM_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [NUM_W-1:0] sh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   rem_nxt;

	// restoring remainder, one dividend bit per cycle
	assign trial   = {rem_q, sh_q[NUM_W-1]};
	assign rem_nxt = (trial >= {1'b0, divisor}) ? (trial - {1'b0, divisor}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nxt[DIV_W-1:0];
			sh_q  <= {sh_q[NUM_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	`FATE_ASSERT_IMP(a_rem_below_div, done_q, rem_q < divisor)

endmodule

// ===== src/fate_dp.sv =====
`include "fixed_array_table_engine_macros.svh"
module fate_dp
	import fate_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CAP_W-1:0]     cfg_wdata,
	input  logic [ACT_W-1:0]     req_action,
	input  logic [POS_W-1:0]     req_position,
	input  logic [WORD_W-1:0]    req_value,
	input  logic [AMT_W-1:0]     req_amount,
	input  fate_cmd_t            cmd,
	output fate_sts_t            sts,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [ST_W-1:0]      res_status,
	output logic [WORD_W-1:0]    res_read_value,
	output logic                 res_found,
	output logic [FPOS_W-1:0]    res_fpos,
	output logic [CNT_OUT_W-1:0] res_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam logic [1:0] PH_LAST = 2'd2;

	// request and state registers
	action_t              act_q;
	logic [POS_W-1:0]     pos_q;
	logic [WORD_W-1:0]    word_q;
	logic [AMT_W-1:0]     amt_q;
	logic [CW-1:0]        count_q;
	logic [CAP_W-1:0]     cap_q;
	logic [1:0]           ph_q;
	logic [CW-1:0]        a_q;
	logic [CW-1:0]        b_q;
	logic [WORD_W-1:0]    hold_q;
	status_t              st_q;
	logic [WORD_W-1:0]    rd_q;
	logic                 fnd_q;
	logic [CW-1:0]        fpos_q;
	logic                 ov_q;
	logic [ST_W-1:0]      o_status_q;
	logic [WORD_W-1:0]    o_rd_q;
	logic                 o_fnd_q;
	logic [FPOS_W-1:0]    o_fpos_q;
	logic [CNT_OUT_W-1:0] o_cnt_q;

	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic [XW-1:0]     a_x;
	logic [XW-1:0]     fpos_x;
	logic [CW-1:0]     a_dn;
	logic [CW-1:0]     a_up;
	logic [CW-1:0]     k;
	logic              mod_done;
	logic [CW-1:0]     rv_lo;
	logic [CW-1:0]     rv_hi;
	logic [CW-1:0]     ridx;
	logic [CW-1:0]     widx;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] rdata;

	assign pos_x  = XW'(pos_q);
	assign cnt_x  = XW'(count_q);
	assign a_x    = XW'(a_q);
	assign fpos_x = XW'(fpos_q);
	assign a_dn   = a_q - CW'(1);
	assign a_up   = a_q + CW'(1);

	// word store
	fate_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(widx[AW-1:0]),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(ridx[AW-1:0]),
		.rdata(rdata)
	);

	// rotate amount modulo count
	fate_mod #(
		.DIV_W(CW),
		.NUM_W(AMT_W)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mod_start),
		.dividend(amt_q),
		.divisor (count_q),
		.done    (mod_done),
		.rem     (k)
	);

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			RA_A:    ridx = a_q;
			RA_B:    ridx = b_q;
			RA_DN:   ridx = a_dn;
			RA_UP:   ridx = a_up;
			RA_POS:  ridx = pos_x[CW-1:0];
			default: ridx = a_q;
		endcase
	end

	// write address and data select
	always_comb begin
		case (cmd.wr_sel)
			WA_A:    widx = a_q;
			WA_B:    widx = b_q;
			WA_POS:  widx = pos_x[CW-1:0];
			default: widx = a_q;
		endcase
		case (cmd.wd_sel)
			WD_RDATA: wdata = rdata;
			WD_HOLD:  wdata = hold_q;
			WD_WORD:  wdata = word_q;
			default:  wdata = rdata;
		endcase
	end

	// bounds of the reversal for the current phase
	always_comb begin
		case (ph_q)
			2'd0: begin
				rv_lo = '0;
				rv_hi = count_q - CW'(1);
			end
			2'd1: begin
				rv_lo = '0;
				rv_hi = k - CW'(1);
			end
			default: begin
				rv_lo = k;
				rv_hi = count_q - CW'(1);
			end
		endcase
	end

	// control state: count, capacity, phase, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
			ph_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.ld_req) begin
				ph_q <= '0;
			end else if (cmd.ph_inc) begin
				ph_q <= ph_q + 2'd1;
			end
			if (cmd.res_ld) begin
				ov_q <= 1'b1;
			end else if (res_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// request capture, indexes and pending result fields
	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			act_q  <= action_t'(req_action);
			pos_q  <= req_position;
			word_q <= req_value;
			amt_q  <= req_amount;
			st_q   <= ST_OK;
			rd_q   <= '0;
			fnd_q  <= 1'b0;
			fpos_q <= '0;
		end else begin
			if (cmd.st_set) begin
				st_q <= cmd.st_code;
			end
			if (cmd.rd_cap) begin
				rd_q <= rdata;
			end
			if (cmd.fnd_set) begin
				fnd_q  <= 1'b1;
				fpos_q <= a_q;
			end
		end
		if (cmd.hold_ld) begin
			hold_q <= rdata;
		end
		case (cmd.ix_op)
			IX_CNT:  a_q <= count_q;
			IX_POS:  a_q <= pos_x[CW-1:0];
			IX_ZERO: a_q <= '0;
			IX_DN:   a_q <= a_dn;
			IX_UP:   a_q <= a_up;
			IX_RV_SET: begin
				a_q <= rv_lo;
				b_q <= rv_hi;
			end
			IX_RV_STEP: begin
				a_q <= a_up;
				b_q <= b_q - CW'(1);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			o_status_q <= st_q;
			o_rd_q     <= rd_q;
			o_fnd_q    <= fnd_q;
			o_fpos_q   <= fpos_x[FPOS_W-1:0];
			o_cnt_q    <= cnt_x[CNT_OUT_W-1:0];
		end
	end

	// status toward the controller
	always_comb begin
		sts.act         = act_q;
		sts.pos_gt_cnt  = pos_x > cnt_x;
		sts.pos_ge_cnt  = pos_x >= cnt_x;
		sts.full        = (cnt_x >= XW'(cap_q)) || (cnt_x >= XW'(CAPACITY));
		sts.cnt_zero    = (count_q == '0);
		sts.ins_more    = a_x > pos_x;
		sts.ins_more_dn = XW'(a_dn) > pos_x;
		sts.up_lt_cnt   = (a_x + XW'(1)) < cnt_x;
		sts.up2_lt_cnt  = (a_x + XW'(2)) < cnt_x;
		sts.a_lt_cnt    = a_x < cnt_x;
		sts.lo_lt_hi    = a_q < b_q;
		sts.match       = (rdata == word_q);
		sts.mod_done    = mod_done;
		sts.k_zero      = (k == '0);
		sts.ph_last     = (ph_q == PH_LAST);
		sts.out_busy    = ov_q && !res_ready;
	end

	assign res_valid      = ov_q;
	assign res_status     = o_status_q;
	assign res_read_value = o_rd_q;
	assign res_found      = o_fnd_q;
	assign res_fpos       = o_fpos_q;
	assign res_count      = o_cnt_q;

	`FATE_ASSERT_ALWAYS(a_count_in_depth, count_q <= CW'(CAPACITY))
	`FATE_ASSERT_IMP(a_write_in_region, cmd.wr_en, XW'(widx) <= cnt_x)

endmodule

// ===== src/fate_ctrl.sv =====
`include "fixed_array_table_engine_macros.svh"
module fate_ctrl
	import fate_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  fate_sts_t sts,
	output fate_cmd_t cmd
);

	typedef enum logic [16:0] {
		S_IDLE     = 17'h00001,
		S_DECODE   = 17'h00002,
		S_START    = 17'h00004,
		S_SH_RD    = 17'h00008,
		S_SH_WR    = 17'h00010,
		S_PUT      = 17'h00020,
		S_GET_WAIT = 17'h00040,
		S_FIND_RD  = 17'h00080,
		S_FIND_CMP = 17'h00100,
		S_MOD      = 17'h00200,
		S_RV_SET   = 17'h00400,
		S_RV_CHK   = 17'h00800,
		S_RV_RLO   = 17'h01000,
		S_RV_RHI   = 17'h02000,
		S_RV_WLO   = 17'h04000,
		S_RV_WHI   = 17'h08000,
		S_DONE     = 17'h10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   is_ins;

	assign is_ins = (sts.act == ACT_INSERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencing of one request
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.ld_req = 1'b1;
					state_d    = S_DECODE;
				end
			end
			// range and capacity checks, loop setup
			S_DECODE: begin
				case (sts.act)
					ACT_INSERT: begin
						if (sts.pos_gt_cnt) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_RANGE;
							state_d     = S_DONE;
						end else if (sts.full) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_FULL;
							state_d     = S_DONE;
						end else begin
							cmd.ix_op = IX_CNT;
							state_d   = S_START;
						end
					end
					ACT_GET: begin
						if (sts.pos_ge_cnt) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_RANGE;
							state_d     = S_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_POS;
							state_d    = S_GET_WAIT;
						end
					end
					ACT_DELETE: begin
						if (sts.pos_ge_cnt) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_RANGE;
							state_d     = S_DONE;
						end else begin
							cmd.ix_op = IX_POS;
							state_d   = S_START;
						end
					end
					ACT_FIND: begin
						cmd.ix_op = IX_ZERO;
						state_d   = S_START;
					end
					ACT_ROTATE: begin
						if (sts.cnt_zero) begin
							state_d = S_DONE;
						end else begin
							cmd.mod_start = 1'b1;
							state_d       = S_MOD;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_START: begin
				case (sts.act)
					ACT_INSERT: state_d = sts.ins_more ? S_SH_RD : S_PUT;
					ACT_DELETE: begin
						if (sts.up_lt_cnt) begin
							state_d = S_SH_RD;
						end else begin
							cmd.cnt_dec = 1'b1;
							state_d     = S_DONE;
						end
					end
					ACT_FIND: state_d = sts.a_lt_cnt ? S_FIND_RD : S_DONE;
					default:  state_d = S_DONE;
				endcase
			end
			// shift one entry: up for insert, down for delete
			S_SH_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = is_ins ? RA_DN : RA_UP;
				state_d    = S_SH_WR;
			end
			S_SH_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WA_A;
				cmd.wd_sel = WD_RDATA;
				cmd.ix_op  = is_ins ? IX_DN : IX_UP;
				if (is_ins) begin
					state_d = sts.ins_more_dn ? S_SH_RD : S_PUT;
				end else if (sts.up2_lt_cnt) begin
					state_d = S_SH_RD;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WA_POS;
				cmd.wd_sel  = WD_WORD;
				cmd.cnt_inc = 1'b1;
				state_d     = S_DONE;
			end
			S_GET_WAIT: begin
				cmd.rd_cap = 1'b1;
				state_d    = S_DONE;
			end
			// linear search
			S_FIND_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_A;
				state_d    = S_FIND_CMP;
			end
			S_FIND_CMP: begin
				if (sts.match) begin
					cmd.fnd_set = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.ix_op = IX_UP;
					state_d   = sts.up_lt_cnt ? S_FIND_RD : S_DONE;
				end
			end
			// rotate by three reversals
			S_MOD: begin
				if (sts.mod_done) begin
					if (sts.k_zero) begin
						state_d = S_DONE;
					end else begin
						cmd.ix_op = IX_RV_SET;
						state_d   = S_RV_CHK;
					end
				end
			end
			S_RV_SET: begin
				cmd.ix_op = IX_RV_SET;
				state_d   = S_RV_CHK;
			end
			S_RV_CHK: begin
				if (sts.lo_lt_hi) begin
					state_d = S_RV_RLO;
				end else if (sts.ph_last) begin
					state_d = S_DONE;
				end else begin
					cmd.ph_inc = 1'b1;
					state_d    = S_RV_SET;
				end
			end
			S_RV_RLO: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_A;
				state_d    = S_RV_RHI;
			end
			S_RV_RHI: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RA_B;
				cmd.hold_ld = 1'b1;
				state_d     = S_RV_WLO;
			end
			S_RV_WLO: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WA_A;
				cmd.wd_sel = WD_RDATA;
				state_d    = S_RV_WHI;
			end
			S_RV_WHI: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WA_B;
				cmd.wd_sel = WD_HOLD;
				cmd.ix_op  = IX_RV_STEP;
				state_d    = S_RV_CHK;
			end
			// hand the result to the output register once it is free
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`FATE_ASSERT_IMP(a_res_into_free_reg, cmd.res_ld, !sts.out_busy)
	`FATE_ASSERT_IMP(a_mod_nonzero_div, cmd.mod_start, !sts.cnt_zero)

endmodule
